@@ sv/pbmd_pkg.sv @@
// ----------------------------------------------------------------------------
// pbmd_pkg
// Shared types and constants of the PCM byte to mono downmix block.
// ----------------------------------------------------------------------------
package pbmd_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS   = 2'd1;

  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned BYTE_W     = 8;

  localparam int unsigned DEF_MAX_CHANNELS = 8;

  // width mode codes; the unused code falls back to 8-bit
  localparam logic [MODE_W-1:0] MODE_U8  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_S16 = 2'd1;
  localparam logic [MODE_W-1:0] MODE_S24 = 2'd2;

  localparam logic [CNT_W-1:0] CNT_ONE = 4'd1;

  typedef struct packed {
    logic [MODE_W-1:0] width_mode;
    logic [CNT_W-1:0]  channels;    // effective count, 1..max
  } cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_EMIT
  } bk_state_t;

endpackage

@@ sv/pbmd_front.sv @@
// ----------------------------------------------------------------------------
// pbmd_front
// Assembles samples from bytes, sums the channels of a frame and pushes each
// finished frame sum into the queue.
// ----------------------------------------------------------------------------
module pbmd_front #(
  parameter int unsigned SUM_W = 19
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pbmd_pkg::cfg_t             cfg,
  input  logic                       cfg_clear,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [pbmd_pkg::BYTE_W-1:0] in_tdata,   // [7:0] raw_byte
  input  logic                       in_tlast,    // end_of_data
  input  logic                       q_full,
  output logic                       q_push,
  output logic [SUM_W-1:0]           q_data
);
  import pbmd_pkg::*;

  logic [1:0]          byte_pos_r, byte_pos_nxt;
  logic [BYTE_W-1:0]   partial_r, partial_nxt;
  logic [CNT_W-1:0]    chan_pos_r, chan_pos_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;

  logic                accept;
  logic [1:0]          last_pos;
  logic                have_sample;
  logic                frame_end;
  logic [SAMPLE_W-1:0] sample;
  logic [SUM_W-1:0]    sum_add;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    if (cfg.width_mode == MODE_S16) begin
      last_pos = 2'd1;
    end else if (cfg.width_mode == MODE_S24) begin
      last_pos = 2'd2;
    end else begin
      last_pos = 2'd0;
    end
  end

  assign have_sample = (byte_pos_r >= last_pos);
  assign frame_end   = have_sample && (chan_pos_r >= (cfg.channels - CNT_ONE));

  // 8-bit: (b - 128) * 256 is the byte with its top bit flipped, in the high half
  assign sample  = (last_pos == 2'd0) ? {in_tdata ^ 8'h80, 8'h00} : {in_tdata, partial_r};
  assign sum_add = sum_r + SUM_W'($signed(sample));

  assign q_push = accept && frame_end;
  assign q_data = sum_add;

  always_comb begin
    byte_pos_nxt = byte_pos_r;
    partial_nxt  = partial_r;
    chan_pos_nxt = chan_pos_r;
    sum_nxt      = sum_r;
    if (accept) begin
      if (have_sample) begin
        byte_pos_nxt = 2'd0;
        partial_nxt  = '0;
        if (frame_end) begin
          chan_pos_nxt = '0;
          sum_nxt      = '0;
        end else begin
          chan_pos_nxt = chan_pos_r + CNT_ONE;
          sum_nxt      = sum_add;
        end
      end else begin
        byte_pos_nxt = byte_pos_r + 2'd1;
        partial_nxt  = in_tdata;
      end
      if (in_tlast) begin
        byte_pos_nxt = 2'd0;
        partial_nxt  = '0;
        chan_pos_nxt = '0;
        sum_nxt      = '0;
      end
    end
    if (cfg_clear) begin
      byte_pos_nxt = 2'd0;
      partial_nxt  = '0;
      chan_pos_nxt = '0;
      sum_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r <= 2'd0;
      partial_r  <= '0;
      chan_pos_r <= '0;
      sum_r      <= '0;
    end else begin
      byte_pos_r <= byte_pos_nxt;
      partial_r  <= partial_nxt;
      chan_pos_r <= chan_pos_nxt;
      sum_r      <= sum_nxt;
    end
  end

  a_byte_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_pos_r != 2'd3)
    else $error("byte position out of range");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("frame pushed into full queue");

  a_first_byte_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tlast) |=> (byte_pos_r == 2'd0 && chan_pos_r == '0))
    else $error("state not cleared after end of data");

endmodule

@@ sv/pbmd_fifo.sv @@
// ----------------------------------------------------------------------------
// pbmd_fifo
// Short queue of frame sums between the byte front end and the divider.
// ----------------------------------------------------------------------------
module pbmd_fifo #(
  parameter int unsigned WIDTH = 19,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("queue count did not follow push");

endmodule

@@ sv/pbmd_back.sv @@
// ----------------------------------------------------------------------------
// pbmd_back
// Divides each frame sum by the channel count, one quotient bit a cycle,
// truncating toward zero, and holds the result in the output register.
// ----------------------------------------------------------------------------
module pbmd_back #(
  parameter int unsigned SUM_W = 19
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [pbmd_pkg::CNT_W-1:0]    divisor,
  input  logic                          q_empty,
  input  logic [SUM_W-1:0]              q_data,
  output logic                          q_pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [pbmd_pkg::SAMPLE_W-1:0] out_tdata    // [15:0] mono_sample
);
  import pbmd_pkg::*;

  localparam int unsigned STEP_W = $clog2(SUM_W + 1);

  bk_state_t         state_r, state_nxt;
  logic [SUM_W-1:0]  dq_r;       // dividend shifting out, quotient shifting in
  logic [CNT_W-1:0]  rem_r;
  logic              neg_r;
  logic [STEP_W-1:0] step_r;
  logic              out_valid_r;
  logic [SAMPLE_W-1:0] out_data_r;

  logic              load, step, emit;
  logic              slot_free;
  logic              last_step;
  logic [CNT_W:0]    rem_sh;
  logic              ge;
  logic [SUM_W-1:0]  mag;
  logic [SUM_W-1:0]  result;

  assign slot_free = !out_valid_r || out_tready;
  assign last_step = (step_r == STEP_W'(SUM_W - 1));
  assign rem_sh    = {rem_r, dq_r[SUM_W-1]};
  assign ge        = (rem_sh >= {1'b0, divisor});
  assign mag       = q_data[SUM_W-1] ? (~q_data + SUM_W'(1)) : q_data;
  assign result    = neg_r ? (~dq_r + SUM_W'(1)) : dq_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        if (last_step) begin
          state_nxt = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (slot_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    load = 1'b0;
    step = 1'b0;
    emit = 1'b0;
    case (state_r)
      BK_IDLE: load = !q_empty;
      BK_DIV:  step = 1'b1;
      BK_EMIT: emit = slot_free;
      default: ;
    endcase
  end

  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dq_r   <= mag;
      rem_r  <= '0;
      neg_r  <= q_data[SUM_W-1];
      step_r <= '0;
    end else if (step) begin
      dq_r   <= {dq_r[SUM_W-2:0], ge};
      rem_r  <= ge ? CNT_W'(rem_sh - {1'b0, divisor}) : rem_sh[CNT_W-1:0];
      step_r <= step_r + STEP_W'(1);
    end
    if (emit) begin
      out_data_r <= result[SAMPLE_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DIV) |-> step_r < STEP_W'(SUM_W))
    else $error("divider step count overrun");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r == BK_DIV)
    else $error("pop did not start a division");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("result not presented after division");

endmodule

@@ sv/pcm_bytes_to_mono_downmix.sv @@
// ----------------------------------------------------------------------------
// pcm_bytes_to_mono_downmix
// Interleaved little-endian PCM bytes to a channel-averaged 16-bit mono stream.
// ----------------------------------------------------------------------------
// Bytes are taken at one per cycle whenever the two-entry frame queue has
// room; the front end assembles 8/16/24-bit samples and sums a frame. Each
// frame sum is divided by the channel count in a shared bit-serial divider
// that loads a sum from the queue, works out the quotient bit by bit and
// emits the result before it takes the next sum, so with short frames the
// divider sets the sustained rate of frames, and with longer frames
// the byte input runs at one byte per cycle. tlast on a byte marks the end
// of data: that byte is processed and any unfinished frame is dropped.
// A write to the width-mode or channel register clears the frame state and
// takes effect at once; write it only while no frame is in flight.
// ----------------------------------------------------------------------------
module pcm_bytes_to_mono_downmix #(
  parameter int unsigned MAX_CHANNELS = pbmd_pkg::DEF_MAX_CHANNELS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [pbmd_pkg::BYTE_W-1:0]       in_tdata,    // [7:0] raw_byte
  input  logic                              in_tlast,    // end_of_data
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pbmd_pkg::SAMPLE_W-1:0]     out_tdata,   // [15:0] mono_sample
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pbmd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pbmd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pbmd_pkg::*;

  localparam int unsigned SUM_W   = SAMPLE_W + $clog2(MAX_CHANNELS);
  localparam int unsigned MAX_EFF = (MAX_CHANNELS > 15) ? 15 : MAX_CHANNELS;
  localparam int unsigned Q_DEPTH = 2;

  logic [MODE_W-1:0] mode_r;
  logic [CNT_W-1:0]  chan_r;
  logic              cfg_wr;
  logic              cfg_clear;
  cfg_t              cfg;

  logic              q_push, q_pop, q_full, q_empty;
  logic [SUM_W-1:0]  q_wdata, q_rdata;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_clear = cfg_wr && (cfg_index == REG_WIDTH_MODE || cfg_index == REG_CHANNELS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_S16;
      chan_r <= CNT_ONE;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_WIDTH_MODE: mode_r <= cfg_data[MODE_W-1:0];
        REG_CHANNELS:   chan_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // zero means one channel, above the maximum saturates
  always_comb begin
    cfg.width_mode = mode_r;
    if (chan_r == '0) begin
      cfg.channels = CNT_ONE;
    end else if (chan_r > CNT_W'(MAX_EFF)) begin
      cfg.channels = CNT_W'(MAX_EFF);
    end else begin
      cfg.channels = chan_r;
    end
  end

  pbmd_front #(
    .SUM_W (SUM_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cfg_clear (cfg_clear),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  pbmd_fifo #(
    .WIDTH (SUM_W),
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  pbmd_back #(
    .SUM_W (SUM_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .divisor    (cfg.channels),
    .q_empty    (q_empty),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_clear |=> (cfg.channels != '0))
    else $error("effective channel count is zero");

  a_cfg_no_effect_beyond: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && !cfg_clear) |=> ($stable(mode_r) && $stable(chan_r)))
    else $error("write beyond the register list changed a register");

  a_chan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cfg.channels <= CNT_W'(MAX_EFF))
    else $error("effective channel count above maximum");

endmodule

@@ sim/pcm_bytes_to_mono_downmix_test.sv @@
// ----------------------------------------------------------------------------
// pcm_bytes_to_mono_downmix_test
// Self-checking bench for the PCM byte to mono downmix block: directed checks
// of sample extremes, width modes, channel counts and end-of-data handling,
// then random byte streams over many register settings. A software downmix
// tracks every accepted byte and queues the mono samples the block must emit.
// ----------------------------------------------------------------------------
module pcm_bytes_to_mono_downmix_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pbmd_pkg::*;

  localparam int unsigned MAX_CH       = DEF_MAX_CHANNELS;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned RANDOM_BYTES = 1700;
  localparam int unsigned RUN_LIMIT_NS = 5_000_000;
  localparam int unsigned MAX_REPORTS  = 10;

  // indexes past the register list, written to check they are ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  // unused width code, behaves as 8-bit
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata   = '0;   // [7:0] raw_byte
  logic                  in_tlast   = 1'b0; // end_of_data
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [SAMPLE_W-1:0]   out_tdata;         // [15:0] mono_sample
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // downmix model state
  logic [MODE_W-1:0]     mode_now;
  logic [CNT_W-1:0]      count_now;
  int unsigned           byte_idx;
  logic [BYTE_W-1:0]     held_byte;
  int unsigned           chan_idx;
  int                    frame_acc;

  logic [SAMPLE_W-1:0]   pending_mono[$];
  int unsigned           mismatches = 0;
  bit                    in_calm    = 1'b0;
  bit                    out_calm   = 1'b0;

  pcm_bytes_to_mono_downmix #(
    .MAX_CHANNELS(MAX_CH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void clear_frame();
    byte_idx  = 0;
    held_byte = '0;
    chan_idx  = 0;
    frame_acc = 0;
  endfunction

  function automatic int unsigned eff_channels();
    if (count_now == '0) return 1;
    if (count_now > MAX_CH) return MAX_CH;
    return 32'(count_now);
  endfunction

  function automatic int unsigned sample_bytes();
    case (mode_now)
      MODE_S16: return 2;
      MODE_S24: return 3;
      default:  return 1;
    endcase
  endfunction

  // one accepted byte through the downmix; queues a mono sample on frame end
  function automatic void mix_byte(input logic [BYTE_W-1:0] b, input logic last);
    int unsigned chans;
    int          smp;
    bit          have;
    int          avg;
    chans = eff_channels();
    have  = 1'b0;
    smp   = 0;
    if (byte_idx + 1 >= sample_bytes()) begin
      if (sample_bytes() == 1) smp = (int'(b) - 128) * 256;
      else smp = int'($signed({b, held_byte}));
      have      = 1'b1;
      byte_idx  = 0;
      held_byte = '0;
    end else begin
      held_byte = b;
      byte_idx  = byte_idx + 1;
    end
    if (have) begin
      frame_acc += smp;
      if (chan_idx + 1 >= chans) begin
        avg = frame_acc / int'(chans);
        pending_mono.push_back(avg[SAMPLE_W-1:0]);
        chan_idx  = 0;
        frame_acc = 0;
      end else begin
        chan_idx++;
      end
    end
    if (last) clear_frame();
  endfunction

  function automatic int unsigned pick_gap(input bit calm);
    if (calm) return 0;
    return $urandom_range(0, 17);
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return 8'h80;
      3:       return 8'h7f;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    int unsigned gap;
    gap = pick_gap(in_calm);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    mix_byte(b, last);
  endtask

  // register writes happen only once every queued sample has come out
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    in_tvalid <= 1'b0;
    while (pending_mono.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_WIDTH_MODE: begin
        mode_now = val[MODE_W-1:0];
        clear_frame();
      end
      REG_CHANNELS: begin
        count_now = val;
        clear_frame();
      end
      default: ;
    endcase
  endtask

  task automatic test_sample_extremes();
    // reset setting: 16-bit, one channel
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h7f, 1'b0);
  endtask

  task automatic test_width_modes();
    // upper data bits set to check the mode field is masked
    write_reg(REG_WIDTH_MODE, {2'b11, MODE_U8});
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b0);
    write_reg(REG_WIDTH_MODE, {2'b01, MODE_S24});
    send_byte(8'h12, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hab, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h7f, 1'b0);
  endtask

  task automatic test_channel_counts();
    // zero channels acts as one, spare mode as 8-bit, last byte closes a frame
    write_reg(REG_WIDTH_MODE, {2'b00, MODE_SPARE});
    write_reg(REG_CHANNELS, 4'd0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    // negative average truncates toward zero
    write_reg(REG_CHANNELS, 4'd3);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    // count above the maximum saturates
    write_reg(REG_CHANNELS, 4'd15);
    repeat (MAX_CH) send_byte(8'h00, 1'b0);
  endtask

  task automatic test_end_of_data();
    write_reg(REG_WIDTH_MODE, {2'b00, MODE_S24});
    write_reg(REG_CHANNELS, 4'd1);
    // end mark mid-sample drops it
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b1);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b0);
    send_byte(8'h05, 1'b0);
  endtask

  task automatic test_ignored_index();
    write_reg(REG_SPARE_A, 4'hf);
    write_reg(REG_SPARE_B, 4'h0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h56, 1'b1);
  endtask

  task automatic test_random_streams();
    int unsigned sent;
    int unsigned phase_len;
    int unsigned done;
    int unsigned frame_bytes;
    int unsigned stream_len;
    logic        last;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_WIDTH_MODE, CFG_DATA_W'($urandom_range(0, 15)));
        write_reg(REG_CHANNELS, CFG_DATA_W'(($urandom_range(0, 1) == 0) ?
                  $urandom_range(1, MAX_CH) : $urandom_range(0, 15)));
      end else begin
        write_reg(REG_CHANNELS, CFG_DATA_W'($urandom_range(0, 15)));
        if ($urandom_range(0, 2) != 0)
          write_reg(REG_WIDTH_MODE, CFG_DATA_W'($urandom_range(0, 15)));
      end
      phase_len = $urandom_range(30, 160);
      done = 0;
      while (done < phase_len) begin
        in_calm     = ($urandom_range(0, 4) == 0);
        out_calm    = ($urandom_range(0, 4) == 0);
        frame_bytes = sample_bytes() * eff_channels();
        // mostly whole frames; some streams cut short
        if ($urandom_range(0, 4) == 0) stream_len = $urandom_range(1, 3 * frame_bytes);
        else stream_len = frame_bytes * $urandom_range(1, 6);
        for (int unsigned k = 0; k < stream_len; k++) begin
          if (k == stream_len - 1) last = ($urandom_range(0, 3) != 0);
          else last = ($urandom_range(0, 63) == 0);
          send_byte(pick_byte(), last);
        end
        done += stream_len;
      end
      sent += done;
    end
  endtask

  // result side ready with random stalls
  initial begin
    int unsigned stall;
    wait (rst_n);
    forever begin
      stall = pick_gap(out_calm);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    logic [SAMPLE_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_mono.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected mono sample %0d", $signed(out_tdata));
      end else begin
        want = pending_mono.pop_front();
        if (out_tdata !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mono sample: expected %0d, got %0d", $signed(want),
                     $signed(out_tdata));
        end
      end
    end
  end

  initial begin
    mode_now  = MODE_S16;
    count_now = CNT_ONE;
    clear_frame();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_sample_extremes();
    test_width_modes();
    test_channel_counts();
    test_end_of_data();
    test_ignored_index();
    test_random_streams();
    in_tvalid <= 1'b0;
    while (pending_mono.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ pcm_bytes_to_mono_downmix.f @@
sv/pbmd_pkg.sv
sv/pbmd_front.sv
sv/pbmd_fifo.sv
sv/pbmd_back.sv
sv/pcm_bytes_to_mono_downmix.sv
sim/pcm_bytes_to_mono_downmix_test.sv
